[rtl/core/clmc_pkg.sv]
// Shared types and constants for the command link mode controller.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package clmc_pkg;

    // Command buffer depth and fill count width
    localparam int CMD_LEN   = 5;
    localparam int CMD_CNT_W = $clog2(CMD_LEN + 1);

    localparam logic [CMD_CNT_W-1:0] CMD_FULL = CMD_CNT_W'(CMD_LEN);
    localparam logic [CMD_CNT_W-1:0] CMD_ONE  = CMD_CNT_W'(1);
    localparam logic [CMD_CNT_W-1:0] CMD_NONE = '0;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [31:0] PRESS_RESET    = 32'd4294967096;

    // Input beat kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_BTN1 = 2'd1;
    localparam logic [1:0] KIND_BTN2 = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    // Machine modes
    localparam logic [1:0] MODE_ENERGIZED = 2'd0;
    localparam logic [1:0] MODE_MOVING    = 2'd1;
    localparam logic [1:0] MODE_LOCKED    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN   = 2'd3;

    // Result kinds
    localparam logic RK_TX_BYTE = 1'b0;
    localparam logic RK_NOTIFY  = 1'b1;

    // Characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_K     = 8'h4B;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] tx_byte;
        logic [1:0] mode;
        logic       last_of_run;
    } t_result;

    // Results of one processed beat, handed to the output buffer
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_proc_out;

endpackage

[rtl/core/command_link_mode_controller.sv]
// Command link mode controller: input register, processing stage and result holder.
// A beat is held in the input register, then its results in the result holder.
// Throughput: one beat per cycle for runs of zero or one result while m_axis_tready
// is high; a two-byte reply in the two-entry result holder stalls the next beat.
// Reset (i_rst_n low, synchronous): mode unknown, buffer empty, tick counter zero,
// press timestamps at minus 200, debounce 200 ms, both streams idle.
module command_link_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // debounce_ms
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] tx_byte, [9:8] mode, zeros
    output logic        m_axis_tuser,  // [0] result_kind
    output logic        m_axis_tlast   // last_of_run
);

    logic [15:0]          r_debounce;
    logic                 r_in_valid, n_in_valid;
    logic [1:0]           r_kind;
    logic [7:0]           r_byte;
    logic                 space;
    logic                 go;
    logic                 accept;
    clmc_pkg::t_proc_out  proc_res;
    clmc_pkg::t_result    head;

    assign go            = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || space;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_debounce <= clmc_pkg::DEBOUNCE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_byte <= s_axis_tdata;
        end
    end

    clmc_proc u_proc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_kind        (r_kind),
        .i_rx_byte     (r_byte),
        .i_debounce_ms (r_debounce),
        .o_res         (proc_res)
    );

    clmc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .i_res   (proc_res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {6'd0, head.mode, head.tx_byte};
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.last_of_run;

endmodule

[rtl/core/clmc_proc.sv]
// Processing stage: mode, command buffer, tick counter and press timestamps.
// Depends on clmc_pkg. Produces zero to two results for each processed beat.
module clmc_proc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_debounce_ms,
    output clmc_pkg::t_proc_out   o_res
);

    logic [1:0]                     r_mode, n_mode;
    logic [clmc_pkg::CMD_CNT_W-1:0] r_cnt, n_cnt;
    // Only the first buffered byte is ever examined: a command matches with one byte only
    logic [7:0]                     r_first, n_first;
    logic [31:0]                    r_ms, n_ms;
    logic [31:0]                    r_lp1, n_lp1;
    logic [31:0]                    r_lp2, n_lp2;

    logic [31:0] diff1, diff2;
    logic        ok1, ok2;
    logic [1:0]  n_count;
    logic        pair_en, notify_en;
    logic [7:0]  pair_ch;
    logic [1:0]  target;
    logic        target_ok;

    assign diff1 = r_ms - r_lp1;
    assign diff2 = r_ms - r_lp2;
    assign ok1   = diff1 > {16'd0, i_debounce_ms};
    assign ok2   = diff2 > {16'd0, i_debounce_ms};

    always_comb begin
        case (r_first)
            clmc_pkg::CH_E: begin
                target    = clmc_pkg::MODE_ENERGIZED;
                target_ok = 1'b1;
            end
            clmc_pkg::CH_A: begin
                target    = clmc_pkg::MODE_MOVING;
                target_ok = 1'b1;
            end
            clmc_pkg::CH_B: begin
                target    = clmc_pkg::MODE_LOCKED;
                target_ok = 1'b1;
            end
            default: begin
                target    = clmc_pkg::MODE_UNKNOWN;
                target_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_ms      = r_ms;
        n_lp1     = r_lp1;
        n_lp2     = r_lp2;
        pair_en   = 1'b0;
        pair_ch   = clmc_pkg::CH_K;
        notify_en = 1'b0;
        if (i_go) begin
            case (i_kind)
                clmc_pkg::KIND_RX: begin
                    if (i_rx_byte == clmc_pkg::CH_COLON) begin
                        n_cnt = clmc_pkg::CMD_NONE;
                    end else if (i_rx_byte == clmc_pkg::CH_CR) begin
                        n_cnt = clmc_pkg::CMD_NONE;
                        if (r_cnt == clmc_pkg::CMD_ONE) begin
                            if (r_first == clmc_pkg::CH_K) begin
                                pair_en = 1'b1;
                                pair_ch = clmc_pkg::CH_K;
                            end else if (target_ok && target != r_mode) begin
                                notify_en = 1'b1;
                                n_mode    = target;
                            end
                        end
                    end else if (r_cnt < clmc_pkg::CMD_FULL) begin
                        if (r_cnt == clmc_pkg::CMD_NONE) begin
                            n_first = i_rx_byte;
                        end
                        n_cnt = r_cnt + clmc_pkg::CMD_ONE;
                    end
                end
                clmc_pkg::KIND_BTN1: begin
                    if (ok1) begin
                        pair_en = 1'b1;
                        pair_ch = (r_mode == clmc_pkg::MODE_ENERGIZED ||
                                   r_mode == clmc_pkg::MODE_UNKNOWN) ?
                                  clmc_pkg::CH_B : clmc_pkg::CH_E;
                        n_lp1   = r_ms;
                    end
                end
                clmc_pkg::KIND_BTN2: begin
                    if (ok2) begin
                        n_lp2 = r_ms;
                        if (r_mode == clmc_pkg::MODE_LOCKED) begin
                            pair_en = 1'b1;
                            pair_ch = clmc_pkg::CH_A;
                        end else if (r_mode == clmc_pkg::MODE_MOVING) begin
                            pair_en = 1'b1;
                            pair_ch = clmc_pkg::CH_B;
                        end
                    end
                end
                default: begin
                    n_ms = r_ms + 32'd1;
                end
            endcase
        end
    end

    always_comb begin
        n_count = pair_en ? 2'd2 : (notify_en ? 2'd1 : 2'd0);
        o_res.count              = n_count;
        o_res.first.result_kind  = notify_en ? clmc_pkg::RK_NOTIFY : clmc_pkg::RK_TX_BYTE;
        o_res.first.tx_byte      = notify_en ? 8'd0 : pair_ch;
        o_res.first.mode         = n_mode;
        o_res.first.last_of_run  = notify_en;
        o_res.second.result_kind = clmc_pkg::RK_TX_BYTE;
        o_res.second.tx_byte     = clmc_pkg::CH_LF;
        o_res.second.mode        = n_mode;
        o_res.second.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= clmc_pkg::MODE_UNKNOWN;
            r_cnt  <= clmc_pkg::CMD_NONE;
            r_ms   <= 32'd0;
            r_lp1  <= clmc_pkg::PRESS_RESET;
            r_lp2  <= clmc_pkg::PRESS_RESET;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_ms   <= n_ms;
            r_lp1  <= n_lp1;
            r_lp2  <= n_lp2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
    end

endmodule

[rtl/core/clmc_out_buf.sv]
// Two-entry result holder between the processing stage and the output stream.
// Depends on clmc_pkg. Takes a whole run of results only when it will be empty.
module clmc_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  clmc_pkg::t_proc_out   i_res,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output clmc_pkg::t_result     o_head
);

    logic [1:0]         r_cnt, n_cnt;
    clmc_pkg::t_result  r_head, n_head;
    clmc_pkg::t_result  r_tail, n_tail;
    logic               pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_head  = r_head;

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        if (i_load) begin
            // buffer is empty or drains this cycle: replace it outright
            n_cnt  = i_res.count;
            n_head = i_res.first;
            n_tail = i_res.second;
        end else if (pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = r_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

[rtl/core/clmc_checker.sv]
// Port-level checks for the command link mode controller, bound to the top level.
// Depends on clmc_pkg for codes and watches the top level's ports.
module clmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // a reply byte is always followed at once by the newline that ends the run
    a_pair_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast && m_axis_tuser == clmc_pkg::RK_TX_BYTE &&
            m_axis_tdata[7:0] == clmc_pkg::CH_LF)
        else $error("first reply byte not followed by newline");

    // notification: zero byte, ends its run, names a known mode
    a_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == clmc_pkg::RK_NOTIFY |->
            m_axis_tdata[7:0] == 8'd0 && m_axis_tlast &&
            m_axis_tdata[9:8] != clmc_pkg::MODE_UNKNOWN)
        else $error("malformed mode notification");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("tdata padding not zero");

endmodule

bind command_link_mode_controller clmc_checker u_clmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
